### src/rgb_bilinear_sampler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RGB bilinear sampler
// Clocked implication checks, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef RGB_BILINEAR_SAMPLER_ASSERT_SVH
`define RGB_BILINEAR_SAMPLER_ASSERT_SVH

// same-cycle implication
`define RBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// next-cycle implication
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

`endif

### src/rbs_pkg.sv
// ---------------------------------------------------------------------------
// rbs_pkg
// Shared constants and payload types of the RGB bilinear sampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbs_pkg;

  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int MAX_HEIGHT_DEF    = 1024;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int COORD_W = 18;
  localparam int INDEX_W = 20;
  localparam int CHAN_W  = 8;
  localparam int DIM_W   = 11;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_MODE  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic MODE_BILINEAR = 1'b0;
  localparam logic MODE_NEAREST  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] pixel_index;
    logic [CHAN_W-1:0]  write_red;
    logic [CHAN_W-1:0]  write_green;
    logic [CHAN_W-1:0]  write_blue;
    logic [COORD_W-1:0] sample_x;
    logic [COORD_W-1:0] sample_y;
  } rbs_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } rbs_out_t;

endpackage

### src/rbs_stream_if.sv
// ---------------------------------------------------------------------------
// rbs_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rbs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/rbs_ram.sv
// ---------------------------------------------------------------------------
// rbs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rgb_bilinear_sampler.sv
// ---------------------------------------------------------------------------
// rgb_bilinear_sampler
// RGB image store with bilinear or nearest sampling at fixed-point coords.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  : valid/ready stream. A write command stores one pixel at
//           pixel_index in the accept cycle and gives no result. A sample
//           command reads the store and gives one result on out_o.
//   out_o : valid/ready stream with the sampled R, G, B channels, held in an
//           output register until the receiver takes it.
//   APB   : image_width, image_height, sample_mode at 0x0, 0x4, 0x8.
// Sequence: a sample walks states over the single pixel memory read port:
//   row base (multiplier), one memory read per neighbour (4 bilinear,
//   1 nearest), a drain step, an output load. Input is accepted only in
//   idle: a write keeps it idle, a sample holds off the next item until
//   its result is loaded.
// Stall: if the previous result is still held, the sequence waits in its
//   output step; input stays blocked until the result register frees up.
// Reset: control and config registers clear (1024 x 1024, bilinear); the
//   pixel memory is not cleared, pixels must be written before sampling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rgb_bilinear_sampler_assert.svh"

module rgb_bilinear_sampler #(
  parameter int MAX_WIDTH     = rbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = rbs_pkg::MAX_HEIGHT_DEF,
  parameter int FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rbs_stream_if.sink                       in_i,
  rbs_stream_if.source                     out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rbs_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rbs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rbs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  import rbs_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int INT_W  = COORD_W - FRACTION_BITS;
  localparam int WX_W   = FRACTION_BITS + 1;
  localparam int WT_W   = 2 * FRACTION_BITS + 1;
  localparam int ACC_W  = 2 * FRACTION_BITS + CHAN_W;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int HALF   = 1 << (FRACTION_BITS - 1);
  localparam int ONE    = 1 << FRACTION_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROW  = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // ---------------- configuration ----------------
  logic [DIM_W-1:0]     image_width_q, image_width_d;
  logic [DIM_W-1:0]     image_height_q, image_height_d;
  logic                 sample_mode_q, sample_mode_d;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_comb begin
    image_width_d  = image_width_q;
    image_height_d = image_height_q;
    sample_mode_d  = sample_mode_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  image_width_d  = pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_d = pwdata[DIM_W-1:0];
        REG_SAMPLE_MODE:  sample_mode_d  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_q);
      REG_SAMPLE_MODE:  prdata = APB_DATA_W'(sample_mode_q);
      default:          prdata = '0;
    endcase
  end

  // effective dimensions: zero reads as one, above the maximum saturates
  logic [WD_W-1:0] dim_w;
  logic [HD_W-1:0] dim_h;
  logic [CW-1:0]   wm1;
  logic [RW-1:0]   hm1;

  always_comb begin
    if (image_width_q == '0) begin
      dim_w = WD_W'(1);
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      dim_w = WD_W'(MAX_WIDTH);
    end else begin
      dim_w = WD_W'(image_width_q);
    end
    if (image_height_q == '0) begin
      dim_h = HD_W'(1);
    end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
      dim_h = HD_W'(MAX_HEIGHT);
    end else begin
      dim_h = HD_W'(image_height_q);
    end
    wm1 = CW'(dim_w - WD_W'(1));
    hm1 = RW'(dim_h - HD_W'(1));
  end

  // ---------------- input decode ----------------
  rbs_in_t                 in_p;
  logic                    in_fire;
  logic                    near;
  logic [COORD_W:0]        sx_rnd, sy_rnd;
  logic [INT_W:0]          cx_raw, cy_raw;
  logic [CW-1:0]           x1, x2;
  logic [RW-1:0]           y1, y2;
  logic [FRACTION_BITS-1:0] fx, fy;

  logic [2:0] state_q, state_d;

  assign in_p     = in_i.payload;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire  = in_i.valid & in_i.ready;
  assign near     = (sample_mode_q == MODE_NEAREST);

  always_comb begin
    sx_rnd = {1'b0, in_p.sample_x} + (COORD_W+1)'(HALF);
    sy_rnd = {1'b0, in_p.sample_y} + (COORD_W+1)'(HALF);
    if (near) begin
      cx_raw = sx_rnd[COORD_W:FRACTION_BITS];
      cy_raw = sy_rnd[COORD_W:FRACTION_BITS];
      fx     = '0;
      fy     = '0;
    end else begin
      cx_raw = {1'b0, in_p.sample_x[COORD_W-1:FRACTION_BITS]};
      cy_raw = {1'b0, in_p.sample_y[COORD_W-1:FRACTION_BITS]};
      fx     = in_p.sample_x[FRACTION_BITS-1:0];
      fy     = in_p.sample_y[FRACTION_BITS-1:0];
    end
    x1 = (32'(cx_raw) > 32'(wm1)) ? wm1 : CW'(cx_raw);
    y1 = (32'(cy_raw) > 32'(hm1)) ? hm1 : RW'(cy_raw);
    x2 = (x1 == wm1) ? x1 : x1 + CW'(1);
    y2 = (y1 == hm1) ? y1 : y1 + RW'(1);
  end

  // ---------------- sample sequence ----------------
  logic [CW-1:0]            x1_q, x2_q;
  logic [RW-1:0]            y1_q, y2_q;
  logic [FRACTION_BITS-1:0] fx_q, fy_q;
  logic                     near_q;
  logic [AW-1:0]            base_top_q, base_bot_q, row_prod;
  logic [1:0]               k_q, k_d;
  logic [1:0]               k_last;
  logic                     rd_vld_q;
  logic [WX_W-1:0]          wx, wy;
  logic [WT_W-1:0]          weight_q;
  logic [ACC_W-1:0]         acc_q [3];
  logic [PIX_W-1:0]         rdata;
  logic                     out_vld_q, out_vld_d;
  rbs_out_t                 out_q;
  logic                     out_load;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [PIX_W-1:0]         ram_wdata;

  assign k_last   = near_q ? 2'd0 : 2'd3;
  assign out_load = (state_q == ST_OUT) && (!out_vld_q || out_o.ready);
  assign row_prod = AW'(y1_q) * AW'(dim_w);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_p.command == CMD_SAMPLE) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        state_d = ST_READ;
        k_d     = 2'd0;
      end
      ST_READ: begin
        if (k_q == k_last) begin
          state_d = ST_LAST;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_LAST: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_vld_d = out_load | (out_vld_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      k_q            <= 2'd0;
      rd_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      image_width_q  <= DIM_RESET;
      image_height_q <= DIM_RESET;
      sample_mode_q  <= MODE_BILINEAR;
    end else begin
      state_q        <= state_d;
      k_q            <= k_d;
      rd_vld_q       <= (state_q == ST_READ);
      out_vld_q      <= out_vld_d;
      image_width_q  <= image_width_d;
      image_height_q <= image_height_d;
      sample_mode_q  <= sample_mode_d;
    end
  end

  // neighbour order: k[0] selects right column, k[1] selects lower row
  assign wx = k_q[0] ? WX_W'(fx_q) : WX_W'(ONE) - WX_W'(fx_q);
  assign wy = k_q[1] ? WX_W'(fy_q) : WX_W'(ONE) - WX_W'(fy_q);

  always_ff @(posedge clk_i) begin
    if (in_fire && in_p.command == CMD_SAMPLE) begin
      x1_q   <= x1;
      x2_q   <= x2;
      y1_q   <= y1;
      y2_q   <= y2;
      fx_q   <= fx;
      fy_q   <= fy;
      near_q <= near;
    end
    if (state_q == ST_ROW) begin
      base_top_q <= row_prod;
      base_bot_q <= row_prod + ((y2_q != y1_q) ? AW'(dim_w) : AW'(0));
    end
    if (state_q == ST_READ) begin
      weight_q <= WT_W'(wx * wy);
    end
    for (int c = 0; c < 3; c++) begin
      if (state_q == ST_ROW) begin
        acc_q[c] <= '0;
      end else if (rd_vld_q) begin
        acc_q[c] <= acc_q[c] + ACC_W'(rdata[c*CHAN_W +: CHAN_W]) * ACC_W'(weight_q);
      end
    end
    if (out_load) begin
      out_q.out_red   <= acc_q[0][2*FRACTION_BITS +: CHAN_W];
      out_q.out_green <= acc_q[1][2*FRACTION_BITS +: CHAN_W];
      out_q.out_blue  <= acc_q[2][2*FRACTION_BITS +: CHAN_W];
    end
  end

  // writes happen only in idle and reads only mid-sequence, so the single
  // memory never sees a read and a write to the same entry in flight
  assign ram_we    = in_fire && (in_p.command == CMD_WRITE)
                     && (32'(in_p.pixel_index) < 32'(DEPTH));
  assign ram_waddr = AW'(in_p.pixel_index);
  assign ram_wdata = {in_p.write_blue, in_p.write_green, in_p.write_red};
  assign ram_re    = (state_q == ST_READ);
  assign ram_raddr = (k_q[1] ? base_bot_q : base_top_q)
                     + (k_q[0] ? AW'(x2_q) : AW'(x1_q));

  rbs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // ---------------- assertions ----------------
  `RBS_ASSERT_SAME(a_no_rw_overlap, clk_i, rst_ni, ram_we, !ram_re)
  `RBS_ASSERT_SAME(a_near_one_read, clk_i, rst_ni,
                   (state_q == ST_READ) && near_q, k_q == 2'd0)
  `RBS_ASSERT_SAME(a_acc_in_seq, clk_i, rst_ni, rd_vld_q,
                   (state_q == ST_READ) || (state_q == ST_LAST))
  `RBS_ASSERT_NEXT(a_last_to_out, clk_i, rst_ni, state_q == ST_LAST,
                   state_q == ST_OUT)

endmodule

### test/rgb_bilinear_sampler_checker.sv
// ---------------------------------------------------------------------------
// rgb_bilinear_sampler_checker
// Watches the input, output and APB ports of the sampler, keeps its own copy
// of the pixel store and the image registers, predicts every sample result
// and compares each output transfer field by field against the oldest
// prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_bilinear_sampler_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  rbs_pkg::rbs_in_t               in_payload_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  rbs_pkg::rbs_out_t              out_payload_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [rbs_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [rbs_pkg::APB_DATA_W-1:0] pwdata_i,
  output int                             mismatches_o,
  output int                             samples_pending_o
);

  import rbs_pkg::*;

  localparam int unsigned FRAC      = FRACTION_BITS_DEF;
  localparam int unsigned ONE       = 1 << FRAC;
  localparam int unsigned HALF      = ONE >> 1;
  localparam int unsigned FRAC_MASK = ONE - 1;

  rbs_out_t         image_mem [int unsigned];
  rbs_out_t         expected_pixels [$];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             mode_reg;
  int               mismatch_total  = 0;
  int               pending_samples = 0;

  assign mismatches_o      = mismatch_total;
  assign samples_pending_o = pending_samples;

  // channel slices of a packed pixel, lowest byte first
  function automatic string chan_name(input int k);
    case (k)
      0:       return "blue";
      1:       return "green";
      default: return "red";
    endcase
  endfunction

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // stimulus never samples a pixel that was not written
  function automatic rbs_out_t fetch_pixel(input int unsigned col, input int unsigned row,
                                           input int unsigned w);
    int unsigned idx;
    idx = row * w + col;
    return image_mem.exists(idx) ? image_mem[idx] : '0;
  endfunction

  function automatic rbs_out_t predict_sample(input rbs_in_t item);
    int unsigned w, h, cx, cy, fx, fy, x2, y2, acc;
    int unsigned wt[4];
    rbs_out_t    px[4];
    rbs_out_t    res;
    w  = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h  = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    cx = 32'(item.sample_x);
    cy = 32'(item.sample_y);
    if (mode_reg == MODE_NEAREST) begin
      cx = (cx + HALF) >> FRAC;
      cy = (cy + HALF) >> FRAC;
      if (cx > w - 1) cx = w - 1;
      if (cy > h - 1) cy = h - 1;
      return fetch_pixel(cx, cy, w);
    end
    fx = cx & FRAC_MASK;
    fy = cy & FRAC_MASK;
    cx = cx >> FRAC;
    cy = cy >> FRAC;
    if (cx > w - 1) cx = w - 1;
    if (cy > h - 1) cy = h - 1;
    x2 = (cx + 1 > w - 1) ? w - 1 : cx + 1;
    y2 = (cy + 1 > h - 1) ? h - 1 : cy + 1;
    px[0] = fetch_pixel(cx, cy, w);
    px[1] = fetch_pixel(x2, cy, w);
    px[2] = fetch_pixel(cx, y2, w);
    px[3] = fetch_pixel(x2, y2, w);
    wt[0] = (ONE - fx) * (ONE - fy);
    wt[1] = fx * (ONE - fy);
    wt[2] = (ONE - fx) * fy;
    wt[3] = fx * fy;
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int n = 0; n < 4; n++) acc += 32'(px[n][8*k +: 8]) * wt[n];
      res[8*k +: 8] = 8'(acc >> (2 * FRAC));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rbs_out_t want;
    if (!rst_ni) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      mode_reg   = MODE_BILINEAR;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2 +: REG_IDX_W])
          REG_IMAGE_WIDTH:  width_reg  = pwdata_i[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = pwdata_i[DIM_W-1:0];
          REG_SAMPLE_MODE:  mode_reg   = pwdata_i[0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with no sample pending, expected none, actual %h",
                   $time, out_payload_i);
          mismatch_total++;
        end else begin
          want = expected_pixels.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (out_payload_i[8*k +: 8] !== want[8*k +: 8]) begin
              $display("%0t: %s mismatch, expected %h, actual %h", $time, chan_name(k),
                       want[8*k +: 8], out_payload_i[8*k +: 8]);
              mismatch_total++;
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (in_payload_i.command == CMD_WRITE) begin
          image_mem[32'(in_payload_i.pixel_index)] = {in_payload_i.write_red,
                                                      in_payload_i.write_green,
                                                      in_payload_i.write_blue};
        end else begin
          expected_pixels.push_back(predict_sample(in_payload_i));
        end
      end
      pending_samples = expected_pixels.size();
    end
  end

endmodule

### test/rgb_bilinear_sampler_tb.sv
// ---------------------------------------------------------------------------
// rgb_bilinear_sampler_tb
// Fills part of the pixel store, then samples it under a series of image
// sizes and modes: directed corner cases first, then random writes and
// samples with bursty input and a stalling receiver. A checker beside the
// block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_bilinear_sampler_tb;
  import rbs_pkg::*;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

  localparam int EDGE_FRAC[4] = '{0, 127, 128, 255};
  localparam int LONG_HOLD    = 400;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    samples_pending;
  int                    hold_ticket = 0;
  int                    burst_left  = 0;
  int unsigned           img_w = MAX_WIDTH_DEF;
  int unsigned           img_h = MAX_HEIGHT_DEF;

  rbs_stream_if #(.payload_t(rbs_in_t))  in_ch ();
  rbs_stream_if #(.payload_t(rbs_out_t)) out_ch ();

  rgb_bilinear_sampler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rgb_bilinear_sampler_checker u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_ch.valid),
    .in_ready_i        (in_ch.ready),
    .in_payload_i      (in_ch.payload),
    .out_valid_i       (out_ch.valid),
    .out_ready_i       (out_ch.ready),
    .out_payload_i     (out_ch.payload),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .mismatches_o      (mismatches),
    .samples_pending_o (samples_pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: rotating stall patterns, plus a long hold-off on request
  initial begin
    int          rx_cycle;
    int          hold_left;
    int          hold_done;
    rx_pattern_e pat;
    rx_cycle  = 0;
    hold_left = 0;
    hold_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_left == 0 && hold_done != hold_ticket) begin
        hold_done = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        pat = rx_pattern_e'((rx_cycle / 97) % 4);
        case (pat)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ((rx_cycle % 7) != 3);
        endcase
      end
    end
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    return (v > lim) ? lim : 32'(v);
  endfunction

  function automatic rbs_in_t make_write(input logic [INDEX_W-1:0] idx, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b);
    rbs_in_t item;
    item.command     = CMD_WRITE;
    item.pixel_index = idx;
    item.write_red   = r;
    item.write_green = g;
    item.write_blue  = b;
    item.sample_x    = COORD_W'($urandom_range(0, 18'h3FFFF));
    item.sample_y    = COORD_W'($urandom_range(0, 18'h3FFFF));
    return item;
  endfunction

  function automatic rbs_in_t make_sample(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y);
    rbs_in_t item;
    item.command     = CMD_SAMPLE;
    item.pixel_index = INDEX_W'($urandom_range(0, 20'hFFFFF));
    item.write_red   = CHAN_W'($urandom_range(0, 255));
    item.write_green = CHAN_W'($urandom_range(0, 255));
    item.write_blue  = CHAN_W'($urandom_range(0, 255));
    item.sample_x    = x;
    item.sample_y    = y;
    return item;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned dim);
    int unsigned v;
    case ($urandom_range(0, 3))
      0: v = ((dim - 1) << FRACTION_BITS_DEF) + $urandom_range(0, 511);
      1: v = $urandom_range(0, 18'h3FFFF);
      2: v = ($urandom_range(0, dim - 1) << FRACTION_BITS_DEF) | EDGE_FRAC[$urandom_range(0, 3)];
      default: v = $urandom_range(0, (dim << FRACTION_BITS_DEF) - 1);
    endcase
    return (v > 18'h3FFFF) ? 18'h3FFFF : v[COORD_W-1:0];
  endfunction

  // offer one item in bursts with random gaps, return once transferred
  task automatic push_item(input rbs_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= item;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // stop offering and let every pending sample come out
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    wait (samples_pending == 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h, input logic mode);
    settle_block();
    write_reg(REG_IMAGE_WIDTH, APB_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, APB_DATA_W'(h));
    write_reg(REG_SAMPLE_MODE, APB_DATA_W'(mode));
    img_w = eff_dim(w, MAX_WIDTH_DEF);
    img_h = eff_dim(h, MAX_HEIGHT_DEF);
  endtask

  initial begin
    logic [DIM_W-1:0] w_set;
    logic [DIM_W-1:0] h_set;
    logic             mode_set;
    int unsigned      h_lim;
    logic [7:0]       shade;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pixels 0..127 back every random image shape (w*h never exceeds 128);
    // the directed edge cases only touch pixels 0, 1, 1022 and 1023
    for (int i = 0; i < 128; i++) begin
      if (i == 1) shade = 8'hFF;
      else if (i == 0) shade = 8'h00;
      else shade = CHAN_W'($urandom_range(0, 255));
      if (i < 2)
        push_item(make_write(INDEX_W'(i), shade, shade, shade));
      else
        push_item(make_write(INDEX_W'(i), shade, CHAN_W'($urandom_range(0, 255)),
                             CHAN_W'($urandom_range(0, 255))));
    end
    push_item(make_write(20'd1022, 8'h00, 8'h00, 8'h00));
    push_item(make_write(20'd1023, 8'hFF, 8'hFF, 8'hFF));
    // top of the store, far outside any image
    push_item(make_write(20'hFFFFF, 8'hFF, 8'hFF, 8'hFF));

    // full-width single row: midpoints, right-edge clamp, saturation
    set_image(11'd1024, 11'd1, MODE_BILINEAR);
    push_item(make_sample(18'd0, 18'd0));
    push_item(make_sample(18'd128, 18'd0));
    push_item(make_sample(18'h000FF, 18'h000FF));
    push_item(make_sample({10'd1022, 8'd128}, 18'd0));
    push_item(make_sample({10'd1023, 8'd200}, 18'd77));
    push_item(make_sample(18'h3FFFF, 18'h3FFFF));

    // single column, nearest: rounding at one half, bottom clamp
    set_image(11'd1, 11'd1024, MODE_NEAREST);
    push_item(make_sample(18'd0, 18'd127));
    push_item(make_sample(18'd0, 18'd128));
    push_item(make_sample(18'h3FFFF, {10'd1022, 8'd128}));
    push_item(make_sample(18'h3FFFF, 18'h3FFFF));

    // zero size reads as one pixel
    set_image(11'd0, 11'd0, MODE_BILINEAR);
    push_item(make_sample(18'd128, 18'd128));
    push_item(make_sample(18'h3FFFF, 18'h3FFFF));

    // oversize width saturates to the maximum
    set_image(11'd2047, 11'd1, MODE_NEAREST);
    push_item(make_sample({10'd1023, 8'd127}, 18'd0));
    push_item(make_sample(18'h3FFFF, 18'h3FFFF));

    set_image(11'd1, 11'd2047, MODE_BILINEAR);
    push_item(make_sample(18'd300, {10'd1022, 8'd128}));
    push_item(make_sample(18'd0, {10'd1023, 8'd255}));

    // random phases, image area kept within the filled pixels
    for (int ph = 0; ph < 6; ph++) begin
      w_set    = (ph % 2 == 1) ? DIM_W'($urandom_range(1, 128)) : DIM_W'($urandom_range(1, 32));
      h_lim    = 128 / w_set;
      h_set    = DIM_W'($urandom_range(1, (h_lim > 64) ? 64 : h_lim));
      mode_set = (ph % 3 == 1) ? MODE_NEAREST : MODE_BILINEAR;
      set_image(w_set, h_set, mode_set);
      if (ph == 1) hold_ticket <= hold_ticket + 1;
      for (int n = 0; n < 50; n++) begin
        if (ph == 3 && n == 40) settle_block();
        if ($urandom_range(0, 3) == 0) begin
          push_item(make_write(INDEX_W'(($urandom_range(0, 4) < 3)
                                          ? $urandom_range(0, img_w * img_h - 1)
                                          : $urandom_range(0, 20'hFFFFF)),
                               CHAN_W'($urandom_range(0, 255)),
                               CHAN_W'($urandom_range(0, 255)),
                               CHAN_W'($urandom_range(0, 255))));
        end else begin
          push_item(make_sample(pick_coord(img_w), pick_coord(img_h)));
        end
      end
    end

    settle_block();
    if (mismatches == 0 && samples_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/rbs_pkg.sv
src/rbs_stream_if.sv
src/rbs_ram.sv
src/rgb_bilinear_sampler.sv
test/rgb_bilinear_sampler_checker.sv
test/rgb_bilinear_sampler_tb.sv
